### rtl/core/hessian_box_filter_response_top_assert.svh
// Assertion macros shared by the Hessian box filter response block
`ifndef HESSIAN_BOX_FILTER_RESPONSE_TOP_ASSERT_SVH
`define HESSIAN_BOX_FILTER_RESPONSE_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define HBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define HBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hbf_pkg.sv
// Shared types and constants of the Hessian box filter response block
`timescale 1ns / 1ps

package hbf_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;

  localparam int EntryW  = 24;   // summed-area table entry
  localparam int CoordW  = 14;   // signed image coordinates
  localparam int DW      = 27;   // second-derivative sums
  localparam int MulW    = 33;   // shared multiplier operand
  localparam int NumW    = 64;   // determinant numerator
  localparam int DenW    = 39;   // 100 * size^4
  localparam int RemW    = 40;
  localparam int FracW   = 16;
  localparam int DvdW    = 60;   // numerator magnitude
  localparam int QuotW   = DvdW + FracW;
  localparam int DivCntW = 7;
  localparam int DetW    = 37;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  localparam logic [8:0] WidthRst  = 9'd256;
  localparam logic [8:0] HeightRst = 9'd256;
  localparam logic [7:0] SizeRst   = 8'd9;
  localparam logic [1:0] StepRst   = 2'd0;
  localparam logic [7:0] SizeMin   = 8'd9;
  localparam logic [7:0] SizeMax   = 8'd249;
  localparam int         DimMin    = 32;

  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegSize   = 2'd2,
    RegStep   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic       func;
    logic [7:0] pixel;
    logic [7:0] query_col;
    logic [7:0] query_row;
  } item_t;

  typedef struct packed {
    logic signed [DetW-1:0] determinant;
    logic                   laplacian_positive;
  } result_t;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/core/hbf_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module hbf_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/hbf_div.sv
// Restoring divider, one quotient bit per cycle, 16 fraction bits
`timescale 1ns / 1ps

module hbf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hbf_pkg::div_req_t req_i,
  output hbf_pkg::div_rsp_t rsp_o
);

  logic                           run_q, run_d;
  logic                           done_q, done_d;
  logic [hbf_pkg::DivCntW-1:0]    cnt_q, cnt_d;
  logic [hbf_pkg::RemW-1:0]       rem_q, rem_d;
  logic [hbf_pkg::QuotW-1:0]      dvd_q, dvd_d;
  logic [hbf_pkg::DenW-1:0]       den_q, den_d;
  logic [hbf_pkg::RemW-1:0]       shifted;
  logic [hbf_pkg::RemW:0]         diff;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem_q[hbf_pkg::RemW-2:0], dvd_q[hbf_pkg::QuotW-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    den_d   = den_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      dvd_d = {req_i.dividend, {hbf_pkg::FracW{1'b0}}};
      den_d = req_i.divisor;
    end else if (run_q) begin
      rem_d = diff[hbf_pkg::RemW] ? shifted : diff[hbf_pkg::RemW-1:0];
      dvd_d = {dvd_q[hbf_pkg::QuotW-2:0], ~diff[hbf_pkg::RemW]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == hbf_pkg::DivCntW'(hbf_pkg::QuotW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      den_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      dvd_q  <= dvd_d;
      den_q  <= den_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

### rtl/core/hessian_box_filter_response_top.sv
// Hessian box filter response: summed-area table loader and determinant query unit
//
// Usage: raise start with an item on item_i while busy is low; the item is
// taken at that clock edge. A load item (func 0) adds one grey pixel to the
// summed-area table in raster order; it gives no result and keeps the block
// busy for a read of the entry in the row above and a write of the current entry.
// A query item (func 1) gives one result on result_o, marked by
// result_valid_o for exactly one cycle, once it has gone through 32
// table reads issued one per cycle on the single RAM read port, 4 passes
// through the shared 33x33 multiplier, 2 scaling steps and 76 steps of the
// bit-serial divider. busy falls in the cycle the result is shown.
// The receiver cannot stall; a result is taken in the cycle it is shown.
// Write registers over the APB-style port only while busy is low (unchecked).
// Reset clears the load position, row accumulator and registers to their
// defaults; the table memory holds nothing defined until it is loaded.
`timescale 1ns / 1ps

module hessian_box_filter_response_top #(
  parameter int MaxWidth  = hbf_pkg::MaxWidthDef,
  parameter int MaxHeight = hbf_pkg::MaxHeightDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hbf_pkg::item_t    item_i,
  output logic              result_valid_o,
  output hbf_pkg::result_t  result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int Depth = MaxWidth * MaxHeight;
  localparam int AW    = $clog2(Depth);
  localparam int ColW  = $clog2(MaxWidth);
  localparam int RowW  = $clog2(MaxHeight);
  localparam int CW    = hbf_pkg::CoordW;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_RD, S_LD_WR, S_Q_READ, S_Q_DRAIN, S_MUL_DD, S_MUL_XY,
    S_MUL_S2, S_MUL_S4, S_NUM_A, S_NUM_B, S_DIV_GO, S_DIV_WAIT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [8:0] width_q, height_q;
  logic [7:0] size_q;
  logic [1:0] step_q;

  // load position and row accumulator
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [15:0]     rsum_q;

  // query working registers
  logic [11:0]                      xc_q, yc_q;
  logic [7:0]                       s_q;
  logic [6:0]                       lobe_q;
  logic [4:0]                       rd_cnt_q;
  logic                             acc_v_q, acc_zero_q;
  logic [4:0]                       acc_idx_q;
  logic [hbf_pkg::EntryW-1:0]       box_acc_q;
  logic signed [hbf_pkg::DW-1:0]    dxx_q, dyy_q, dxy_q;
  logic signed [hbf_pkg::NumW-1:0]  p1_q, p2_q, num_q;
  logic [31:0]                      sq_q;
  logic [hbf_pkg::DenW-1:0]         den_q;
  logic                             neg_q, lap_q;
  hbf_pkg::result_t                 result_q;
  logic                             result_valid_q;

  logic accept, cfg_we;
  logic acc_query, acc_load;
  logic signed [CW-1:0] eff_w, eff_h;
  logic [7:0]  s_clamp;
  logic [15:0] lobe_prod;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (hbf_pkg::reg_idx_e'(paddr[3:2]))
      hbf_pkg::RegWidth:  prdata = {23'b0, width_q};
      hbf_pkg::RegHeight: prdata = {23'b0, height_q};
      hbf_pkg::RegSize:   prdata = {24'b0, size_q};
      hbf_pkg::RegStep:   prdata = {30'b0, step_q};
      default:            prdata = '0;
    endcase
  end

  // saturate registers to their usable ranges
  always_comb begin
    eff_w = CW'(width_q);
    if (eff_w < CW'(hbf_pkg::DimMin)) eff_w = CW'(hbf_pkg::DimMin);
    else if (eff_w > CW'(MaxWidth)) eff_w = CW'(MaxWidth);
    eff_h = CW'(height_q);
    if (eff_h < CW'(hbf_pkg::DimMin)) eff_h = CW'(hbf_pkg::DimMin);
    else if (eff_h > CW'(MaxHeight)) eff_h = CW'(MaxHeight);
    s_clamp = size_q;
    if (s_clamp < hbf_pkg::SizeMin) s_clamp = hbf_pkg::SizeMin;
    else if (s_clamp > hbf_pkg::SizeMax) s_clamp = hbf_pkg::SizeMax;
    // size / 3 through a reciprocal multiply, exact for sizes below 256
    lobe_prod = 16'(s_clamp) * 16'd171;
  end

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign acc_query = accept && (item_i.func == hbf_pkg::FuncQuery);
  assign acc_load  = accept && (item_i.func == hbf_pkg::FuncLoad);

  // ---------------- table memory ----------------
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr, ld_raddr, q_addr;
  logic [hbf_pkg::EntryW-1:0] ram_wdata, ram_rdata;

  hbf_ram #(
    .Width(hbf_pkg::EntryW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // load addressing: entry above is read, then the current entry written
  always_comb begin
    ld_raddr  = AW'(row_q - 1'b1) * AW'(MaxWidth) + AW'(col_q);
    ram_waddr = AW'(row_q) * AW'(MaxWidth) + AW'(col_q);
    ram_wdata = ((row_q != '0) ? ram_rdata : '0) + hbf_pkg::EntryW'(rsum_q);
    ram_we    = (state_q == S_LD_WR);
    ram_raddr = (state_q == S_Q_READ) ? q_addr : ld_raddr;
  end

  // next load position
  logic [ColW:0] col_inc;
  logic [RowW:0] row_inc;
  assign col_inc = {1'b0, col_q} + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;

  // ---------------- box corner generation ----------------
  logic signed [CW-1:0] xs, ys, ls, hs, bs, ss, bx, by, bw, bh;
  logic signed [CW-1:0] x0, x1, y0, y1, tx, ty, tx_m1, ty_m1;
  logic                 corner_zero;

  function automatic logic signed [CW-1:0] clampc(input logic signed [CW-1:0] v,
                                                   input logic signed [CW-1:0] hi);
    logic signed [CW-1:0] r;
    r = v;
    if (v < 0) r = '0;
    else if (v > hi) r = hi;
    return r;
  endfunction

  always_comb begin
    xs = CW'(xc_q);
    ys = CW'(yc_q);
    ls = CW'(lobe_q);
    hs = CW'(lobe_q[6:1]);
    bs = CW'(s_q[7:1]);
    ss = CW'(s_q);
    case (rd_cnt_q[4:2])
      3'd0: begin
        bx = xs - bs; by = ys - ls + CW'(1); bw = ss; bh = (ls <<< 1) - CW'(1);
      end
      3'd1: begin
        bx = xs - hs; by = ys - ls + CW'(1); bw = ls; bh = (ls <<< 1) - CW'(1);
      end
      3'd2: begin
        bx = xs - ls + CW'(1); by = ys - bs; bw = (ls <<< 1) - CW'(1); bh = ss;
      end
      3'd3: begin
        bx = xs - ls + CW'(1); by = ys - hs; bw = (ls <<< 1) - CW'(1); bh = ls;
      end
      3'd4: begin bx = xs - ls; by = ys - ls; bw = ls; bh = ls; end
      3'd5: begin bx = xs + CW'(1); by = ys - ls; bw = ls; bh = ls; end
      3'd6: begin bx = xs - ls; by = ys + CW'(1); bw = ls; bh = ls; end
      default: begin bx = xs + CW'(1); by = ys + CW'(1); bw = ls; bh = ls; end
    endcase
    x0 = clampc(bx, eff_w);
    x1 = clampc(bx + bw, eff_w);
    y0 = clampc(by, eff_h);
    y1 = clampc(by + bh, eff_h);
    // corners in order: far-far add, far-near sub, near-far sub, near-near add
    tx = rd_cnt_q[1] ? x0 : x1;
    ty = rd_cnt_q[0] ? y0 : y1;
    corner_zero = (tx == '0) || (ty == '0);
    tx_m1 = tx - CW'(1);
    ty_m1 = ty - CW'(1);
    q_addr = AW'(ty_m1) * AW'(MaxWidth) + AW'(tx_m1);
  end

  // ---------------- box sum accumulation ----------------
  logic [hbf_pkg::EntryW-1:0]    term, base, box_sum;
  logic signed [hbf_pkg::DW-1:0] box_val, box_x3;

  always_comb begin
    term    = acc_zero_q ? '0 : ram_rdata;
    base    = (acc_idx_q[1:0] == 2'd0) ? '0 : box_acc_q;
    box_sum = (acc_idx_q[1] ^ acc_idx_q[0]) ? base - term : base + term;
    box_val = hbf_pkg::DW'(box_sum);
    box_x3  = box_val + (box_val <<< 1);
  end

  // ---------------- shared multiplier ----------------
  logic signed [hbf_pkg::MulW-1:0]   mul_a, mul_b;
  logic signed [2*hbf_pkg::MulW-1:0] mul_p;

  always_comb begin
    case (state_q)
      S_MUL_DD: begin mul_a = hbf_pkg::MulW'(dxx_q); mul_b = hbf_pkg::MulW'(dyy_q); end
      S_MUL_XY: begin mul_a = hbf_pkg::MulW'(dxy_q); mul_b = hbf_pkg::MulW'(dxy_q); end
      S_MUL_S2: begin mul_a = hbf_pkg::MulW'(s_q);   mul_b = hbf_pkg::MulW'(s_q);   end
      S_MUL_S4: begin mul_a = hbf_pkg::MulW'(sq_q);  mul_b = hbf_pkg::MulW'(sq_q);  end
      default:  begin mul_a = '0;                    mul_b = '0;                    end
    endcase
    mul_p = mul_a * mul_b;
  end

  logic signed [hbf_pkg::DW:0] dsum;
  assign dsum = (hbf_pkg::DW+1)'(dxx_q) + (hbf_pkg::DW+1)'(dyy_q);

  // ---------------- divider ----------------
  hbf_pkg::div_req_t div_req;
  hbf_pkg::div_rsp_t div_rsp;
  logic signed [hbf_pkg::NumW-1:0] num_abs;

  assign num_abs          = num_q[hbf_pkg::NumW-1] ? -num_q : num_q;
  assign div_req.start    = (state_q == S_DIV_GO);
  assign div_req.dividend = num_abs[hbf_pkg::DvdW-1:0];
  assign div_req.divisor  = den_q;

  hbf_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // saturate quotient into 37-bit signed fixed point
  logic [hbf_pkg::DvdW-1:0]      q_abs;
  logic [hbf_pkg::FracW-1:0]     f_abs;
  logic [hbf_pkg::DetW-1:0]      det;

  always_comb begin
    q_abs = div_rsp.quotient[hbf_pkg::QuotW-1:hbf_pkg::FracW];
    f_abs = div_rsp.quotient[hbf_pkg::FracW-1:0];
    if (!neg_q) begin
      if (q_abs[hbf_pkg::DvdW-1:20] != '0) det = {1'b0, 20'hFFFFF, f_abs};
      else det = {1'b0, q_abs[19:0], f_abs};
    end else begin
      if ((q_abs[hbf_pkg::DvdW-1:21] != '0) ||
          (q_abs[20] && ((q_abs[19:0] != '0) || (f_abs != '0)))) begin
        det = {1'b1, {(hbf_pkg::DetW-1){1'b0}}};
      end else begin
        det = -{q_abs[20:0], f_abs};
      end
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      width_q        <= hbf_pkg::WidthRst;
      height_q       <= hbf_pkg::HeightRst;
      size_q         <= hbf_pkg::SizeRst;
      step_q         <= hbf_pkg::StepRst;
      col_q          <= '0;
      row_q          <= '0;
      rsum_q         <= '0;
      xc_q           <= '0;
      yc_q           <= '0;
      s_q            <= '0;
      lobe_q         <= '0;
      rd_cnt_q       <= '0;
      acc_v_q        <= 1'b0;
      acc_zero_q     <= 1'b0;
      acc_idx_q      <= '0;
      box_acc_q      <= '0;
      dxx_q          <= '0;
      dyy_q          <= '0;
      dxy_q          <= '0;
      p1_q           <= '0;
      p2_q           <= '0;
      num_q          <= '0;
      sq_q           <= '0;
      den_q          <= '0;
      neg_q          <= 1'b0;
      lap_q          <= 1'b0;
      result_q       <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;

      // register writes
      if (cfg_we) begin
        case (hbf_pkg::reg_idx_e'(paddr[3:2]))
          hbf_pkg::RegWidth:  width_q  <= pwdata[8:0];
          hbf_pkg::RegHeight: height_q <= pwdata[8:0];
          hbf_pkg::RegSize:   size_q   <= pwdata[7:0];
          hbf_pkg::RegStep:   step_q   <= pwdata[1:0];
          default: ;
        endcase
      end

      // track the read issued last cycle
      acc_v_q    <= (state_q == S_Q_READ);
      acc_idx_q  <= rd_cnt_q;
      acc_zero_q <= corner_zero;

      // fold returning table data into box sums and derivative sums
      if (acc_v_q) begin
        box_acc_q <= box_sum;
        if (acc_idx_q[1:0] == 2'd3) begin
          case (acc_idx_q[4:2])
            3'd0:    dxx_q <= dxx_q + box_val;
            3'd1:    dxx_q <= dxx_q - box_x3;
            3'd2:    dyy_q <= dyy_q + box_val;
            3'd3:    dyy_q <= dyy_q - box_x3;
            3'd4:    dxy_q <= dxy_q + box_val;
            3'd5:    dxy_q <= dxy_q - box_val;
            3'd6:    dxy_q <= dxy_q - box_val;
            default: dxy_q <= dxy_q + box_val;
          endcase
        end
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (item_i.func == hbf_pkg::FuncLoad) begin
              rsum_q  <= (col_q == '0) ? 16'(item_i.pixel) : rsum_q + 16'(item_i.pixel);
              state_q <= S_LD_RD;
            end else begin
              xc_q     <= 12'(item_i.query_col) << step_q;
              yc_q     <= 12'(item_i.query_row) << step_q;
              s_q      <= s_clamp;
              lobe_q   <= lobe_prod[15:9];
              rd_cnt_q <= '0;
              dxx_q    <= '0;
              dyy_q    <= '0;
              dxy_q    <= '0;
              state_q  <= S_Q_READ;
            end
          end
        end
        S_LD_RD: state_q <= S_LD_WR;
        S_LD_WR: begin
          // advance raster position, wrapping at the frame edges
          if (col_inc >= (ColW+1)'(eff_w)) begin
            col_q <= '0;
            if (row_inc >= (RowW+1)'(eff_h)) row_q <= '0;
            else row_q <= row_inc[RowW-1:0];
          end else begin
            col_q <= col_inc[ColW-1:0];
          end
          state_q <= S_IDLE;
        end
        S_Q_READ: begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
          if (rd_cnt_q == 5'd31) state_q <= S_Q_DRAIN;
        end
        S_Q_DRAIN: state_q <= S_MUL_DD;
        S_MUL_DD: begin
          p1_q    <= mul_p[hbf_pkg::NumW-1:0];
          lap_q   <= !dsum[hbf_pkg::DW];
          state_q <= S_MUL_XY;
        end
        S_MUL_XY: begin
          p2_q    <= mul_p[hbf_pkg::NumW-1:0];
          state_q <= S_MUL_S2;
        end
        S_MUL_S2: begin
          sq_q    <= mul_p[31:0];
          state_q <= S_MUL_S4;
        end
        S_MUL_S4: begin
          sq_q    <= mul_p[31:0];
          state_q <= S_NUM_A;
        end
        S_NUM_A: begin
          // scale by 100 with shifts and adds
          num_q   <= (p1_q <<< 6) + (p1_q <<< 5) + (p1_q <<< 2);
          den_q   <= (hbf_pkg::DenW'(sq_q) << 6) + (hbf_pkg::DenW'(sq_q) << 5) +
                     (hbf_pkg::DenW'(sq_q) << 2);
          state_q <= S_NUM_B;
        end
        S_NUM_B: begin
          // subtract 81 times the squared cross term
          num_q   <= num_q - ((p2_q <<< 6) + (p2_q <<< 4) + p2_q);
          state_q <= S_DIV_GO;
        end
        S_DIV_GO: begin
          neg_q   <= num_q[hbf_pkg::NumW-1];
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            result_q.determinant        <= det;
            result_q.laplacian_positive <= lap_q;
            result_valid_q              <= 1'b1;
            state_q                     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // ---------------- assertions ----------------
`include "hessian_box_filter_response_top_assert.svh"

  `HBF_ASSERT_NOW(a_result_idle, result_valid_o, !busy, "result shown while busy")
  `HBF_ASSERT_NEXT(a_query_busy, acc_query, busy && !result_valid_o, "query did not start work")
  `HBF_ASSERT_NEXT(a_load_silent, acc_load, !result_valid_o, "load transfer produced a result")
  `HBF_ASSERT_NOW(a_write_load, ram_we, busy && !div_rsp.done, "table written outside a load")

endmodule
